// File: hw/rtl/tnkh_pkg.sv
// Shared constants and types for the thread name keyword hasher.
// Holds the hash constants, the keyword table and the cell control struct.
// No dependencies.
package tnkh_pkg;

  localparam int NAME_W = 8;
  localparam int HASH_W = 32;
  localparam int PICK_W = 3;

  localparam logic [HASH_W-1:0] HASH_BASIS = 32'd2166136261;
  localparam logic [HASH_W-1:0] HASH_PRIME = 32'd16777619;

  localparam int DEF_POOL_SIZE = 8;

  localparam int KEY_COUNT = 9;
  localparam int KEY_MAX   = 6;

  localparam int KEY_LENS [KEY_COUNT] = '{5, 4, 4, 5, 5, 3, 5, 6, 6};

  localparam logic [NAME_W-1:0] KEY_CHARS [KEY_COUNT][KEY_MAX] = '{
    '{"f", "r", "i", "d", "a", 8'h00},
    '{"g", "u", "m", "-", 8'h00, 8'h00},
    '{"g", "u", "m", "_", 8'h00, 8'h00},
    '{"g", "m", "a", "i", "n", 8'h00},
    '{"g", "d", "b", "u", "s", 8'h00},
    '{"g", "j", "s", 8'h00, 8'h00, 8'h00},
    '{"g", "-", "i", "o", "-", 8'h00},
    '{"g", "-", "v", "f", "s", "-"},
    '{"g", "-", "m", "a", "i", "n"}
  };

  typedef logic [KEY_COUNT-1:0] key_vec_t;

  typedef struct packed {
    logic advance;
    logic clear;
  } cell_ctrl_t;

endpackage

// File: hw/rtl/tnkh_cell.sv
// One position of the keyword matcher row.
// Holds, per keyword, whether the keyword prefix up to this position ends at
// the previous byte. Depends on tnkh_pkg.
module tnkh_cell
  import tnkh_pkg::*;
#(
  parameter int POS = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  cell_ctrl_t        ctrl,
  input  logic [NAME_W-1:0] name_byte,
  input  key_vec_t          prev,
  output key_vec_t          hit,
  output key_vec_t          state
);

  always_comb begin
    for (int k = 0; k < KEY_COUNT; k++) begin
      hit[k] = prev[k] && (POS < KEY_LENS[k]) && (name_byte == KEY_CHARS[k][POS]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (ctrl.advance) begin
      state <= ctrl.clear ? '0 : hit;
    end
  end

endmodule

// File: hw/rtl/tnkh_mod.sv
// Result pipeline: folds the final hash modulo the pool size and holds the result.
// Four stages, the last is the output register. Depends on tnkh_pkg.
module tnkh_mod
  import tnkh_pkg::*;
#(
  parameter int POOL_SIZE = DEF_POOL_SIZE
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [HASH_W-1:0] hash,
  input  logic              suspect,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              is_suspect,
  output logic [PICK_W-1:0] pick
);

  localparam int FOLD_W = 11;
  localparam int SHIFT  = 20;
  localparam int W0 = 1 % POOL_SIZE;
  localparam int W1 = (W0 * 16) % POOL_SIZE;
  localparam int W2 = (W1 * 16) % POOL_SIZE;
  localparam int W3 = (W2 * 16) % POOL_SIZE;
  localparam int W4 = (W3 * 16) % POOL_SIZE;
  localparam int W5 = (W4 * 16) % POOL_SIZE;
  localparam int W6 = (W5 * 16) % POOL_SIZE;
  localparam int W7 = (W6 * 16) % POOL_SIZE;
  localparam logic [3:0] WT [8] = '{4'(W0), 4'(W1), 4'(W2), 4'(W3),
                                    4'(W4), 4'(W5), 4'(W6), 4'(W7)};
  localparam int unsigned RECIP = ((1 << SHIFT) + POOL_SIZE - 1) / POOL_SIZE;
  localparam logic [31:0] RECIP_V = 32'(RECIP);
  localparam logic [15:0] POOL_V  = 16'(POOL_SIZE);

  logic              v1, v2, v3;
  logic              ready2, ready3, ready4;
  logic [HASH_W-1:0] h1;
  logic              sus1, sus2, sus3;
  logic [FOLD_W-1:0] fold, sum2, sum3;
  logic [FOLD_W-1:0] q3;
  logic [31:0]       prod;
  logic [15:0]       qp;
  logic [FOLD_W-1:0] rem;

  assign ready4   = !out_valid || out_ready;
  assign ready3   = !v3 || ready4;
  assign ready2   = !v2 || ready3;
  assign in_ready = !v1 || ready2;

  always_comb begin
    fold = '0;
    for (int i = 0; i < 8; i++) begin
      fold = fold + FOLD_W'(h1[4*i +: 4]) * FOLD_W'(WT[i]);
    end
  end

  assign prod = {{(32-FOLD_W){1'b0}}, sum2} * RECIP_V;
  assign qp   = {{(16-FOLD_W){1'b0}}, q3} * POOL_V;
  assign rem  = sum3 - qp[FOLD_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) v1 <= in_valid;
      if (ready2)   v2 <= v1;
      if (ready3)   v3 <= v2;
      if (ready4)   out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      h1   <= hash;
      sus1 <= suspect;
    end
    if (ready2) begin
      sum2 <= fold;
      sus2 <= sus1;
    end
    if (ready3) begin
      q3   <= prod[SHIFT+FOLD_W-1:SHIFT];
      sum3 <= sum2;
      sus3 <= sus2;
    end
    if (ready4) begin
      is_suspect <= sus3;
      pick       <= sus3 ? rem[PICK_W-1:0] : '0;
    end
  end

`ifndef SYNTHESIS
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    v3 |-> rem < FOLD_W'(POOL_SIZE))
    else $error("remainder out of range");
  a_clean_pick: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_suspect |-> pick == '0)
    else $error("pick set on a clean name");
  a_fill: assert property (@(posedge clk) disable iff (rst)
    v3 && ready4 |=> out_valid)
    else $error("result lost entering the output register");
`endif

endmodule

// File: hw/rtl/thread_name_keyword_hasher.sv
// Top level of the thread name keyword hasher.
// Instantiates the matcher cell row (tnkh_cell) and the result pipeline
// (tnkh_mod); depends on tnkh_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready, name_byte, last_byte) carries one
//   character of a name per transfer; last_byte marks the final character.
//   Output channel (out_valid/out_ready, is_suspect, pick) carries one result
//   per name: is_suspect is set if any keyword occurred in the name, and pick
//   is the FNV-1a hash of the name modulo POOL_SIZE (low 3 bits), 0 if clean.
//   Throughput: one byte per cycle while in_ready is high. The hash multiply
//   and the keyword cell row each update on every accepted byte, so names
//   follow back to back. Result path: the first of the four modulo fold stages
//   loads at the last byte's transfer; the fold sum, quotient and output follow.
//   Stall: the result pipeline holds up to four results; in_ready drops only
//   when all four stages are full and out_ready is low.
//   Reset: rst (synchronous) restores the hash basis, clears the cells and
//   the sticky flag and empties the result pipeline. The hash basis and the
//   cleared cells and sticky flag are also restored after each last byte.
module thread_name_keyword_hasher
  import tnkh_pkg::*;
#(
  parameter int POOL_SIZE = DEF_POOL_SIZE
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [NAME_W-1:0] name_byte,
  input  logic              last_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              is_suspect,
  output logic [PICK_W-1:0] pick
);

  logic [HASH_W-1:0] hash, hash_next;
  logic              seen, seen_next;
  logic              accept;
  logic              match;
  key_vec_t          match_vec;
  key_vec_t          cell_prev  [KEY_MAX];
  key_vec_t          cell_hit   [KEY_MAX];
  key_vec_t          cell_state [KEY_MAX];
  cell_ctrl_t        ctrl;

  assign accept       = in_valid && in_ready;
  assign ctrl.advance = accept;
  assign ctrl.clear   = last_byte;

  for (genvar p = 0; p < KEY_MAX; p++) begin : g_cell
    if (p == 0) begin : g_head
      assign cell_prev[p] = '1;
    end else begin : g_body
      assign cell_prev[p] = cell_state[p-1];
    end
    tnkh_cell #(.POS(p)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .name_byte (name_byte),
      .prev      (cell_prev[p]),
      .hit       (cell_hit[p]),
      .state     (cell_state[p])
    );
  end

  for (genvar k = 0; k < KEY_COUNT; k++) begin : g_match
    assign match_vec[k] = cell_hit[KEY_LENS[k]-1][k];
  end

  assign match     = |match_vec;
  assign seen_next = seen || match;
  assign hash_next = (hash ^ {{(HASH_W-NAME_W){1'b0}}, name_byte}) * HASH_PRIME;

  always_ff @(posedge clk) begin
    if (rst) begin
      hash <= HASH_BASIS;
      seen <= 1'b0;
    end else if (accept) begin
      hash <= last_byte ? HASH_BASIS : hash_next;
      seen <= last_byte ? 1'b0 : seen_next;
    end
  end

  tnkh_mod #(.POOL_SIZE(POOL_SIZE)) u_mod (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (accept && last_byte),
    .in_ready   (in_ready),
    .hash       (hash_next),
    .suspect    (seen_next),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .is_suspect (is_suspect),
    .pick       (pick)
  );

`ifndef SYNTHESIS
  a_name_clear: assert property (@(posedge clk) disable iff (rst)
    accept && last_byte |=> hash == HASH_BASIS && !seen && cell_state[0] == '0)
    else $error("state not restored after last byte");
  a_sticky: assert property (@(posedge clk) disable iff (rst)
    accept && !last_byte && match |=> seen)
    else $error("keyword match not recorded");
  a_stall_only: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without an output stall");
`endif

endmodule

// File: bench/tb_thread_name_keyword_hasher.sv
// Testbench for thread_name_keyword_hasher: random and directed names, with a
// scoreboard that tracks the name hash, the byte window and the keyword flag.
// Depends on tnkh_pkg and the block's RTL.
`timescale 1ns / 1ps

localparam int POOL = tnkh_pkg::DEF_POOL_SIZE;
localparam logic [31:0] POOL_U = POOL;
localparam int KW_NUM = 9;
localparam int KW_LEN [KW_NUM] = '{5, 4, 4, 5, 5, 3, 5, 6, 6};
localparam logic [7:0] KW_SEQ [KW_NUM][6] = '{
  '{8'h66, 8'h72, 8'h69, 8'h64, 8'h61, 8'h00},
  '{8'h67, 8'h75, 8'h6d, 8'h2d, 8'h00, 8'h00},
  '{8'h67, 8'h75, 8'h6d, 8'h5f, 8'h00, 8'h00},
  '{8'h67, 8'h6d, 8'h61, 8'h69, 8'h6e, 8'h00},
  '{8'h67, 8'h64, 8'h62, 8'h75, 8'h73, 8'h00},
  '{8'h67, 8'h6a, 8'h73, 8'h00, 8'h00, 8'h00},
  '{8'h67, 8'h2d, 8'h69, 8'h6f, 8'h2d, 8'h00},
  '{8'h67, 8'h2d, 8'h76, 8'h66, 8'h73, 8'h2d},
  '{8'h67, 8'h2d, 8'h6d, 8'h61, 8'h69, 8'h6e}
};

typedef struct {
  logic       susp;
  logic [2:0] pk;
} verdict_t;

class verdict_board;
  logic [31:0] fnv;
  logic [7:0]  win [5];
  bit          hit;
  verdict_t    pending [$];
  int          mismatches;

  function new();
    clear_name();
    mismatches = 0;
  endfunction

  function void clear_name();
    fnv = tnkh_pkg::HASH_BASIS;
    foreach (win[i]) win[i] = 8'h00;
    hit = 1'b0;
  endfunction

  function bit ends_keyword(logic [7:0] cur);
    logic [7:0] tail [6];
    bit ok;
    int i;
    int k;
    for (i = 0; i < 5; i++) tail[i] = win[i];
    tail[5] = cur;
    for (k = 0; k < KW_NUM; k++) begin
      ok = 1'b1;
      for (i = 0; i < KW_LEN[k]; i++) begin
        if (tail[6 - KW_LEN[k] + i] != KW_SEQ[k][i]) ok = 1'b0;
      end
      if (ok) return 1'b1;
    end
    return 1'b0;
  endfunction

  function void take_byte(logic [7:0] b, logic last);
    verdict_t v;
    logic [31:0] rem;
    int i;
    fnv = (fnv ^ {24'd0, b}) * tnkh_pkg::HASH_PRIME;
    if (ends_keyword(b)) hit = 1'b1;
    for (i = 0; i < 4; i++) win[i] = win[i + 1];
    win[4] = b;
    if (last) begin
      rem = fnv % POOL_U;
      v.susp = hit;
      v.pk = hit ? rem[2:0] : 3'd0;
      pending.insert(pending.size(), v);
      clear_name();
    end
  endfunction

  function void check_verdict(logic s, logic [2:0] p);
    verdict_t v;
    if (pending.size() == 0) begin
      $error("is_suspect: no name pending, actual %0d (pick %0d)", s, p);
      mismatches++;
      return;
    end
    v = pending.pop_front();
    if (s !== v.susp) begin
      $error("is_suspect: expected %0d, actual %0d", v.susp, s);
      mismatches++;
    end
    if (p !== v.pk) begin
      $error("pick: expected %0d, actual %0d", v.pk, p);
      mismatches++;
    end
  endfunction
endclass

module tb_thread_name_keyword_hasher;
  import tnkh_pkg::*;

  localparam int ITEMS = 1550;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [NAME_W-1:0] name_byte = '0;
  logic              last_byte = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              is_suspect;
  logic [PICK_W-1:0] pick;

  verdict_board board;
  logic [7:0]   name_q [$];
  int           bytes_moved = 0;
  int           rx_hold = 0;
  int           rx_phase = 0;
  bit           rx_calm = 1'b0;

  thread_name_keyword_hasher #(.POOL_SIZE(POOL)) u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .name_byte (name_byte),
    .last_byte (last_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .is_suspect(is_suspect),
    .pick      (pick)
  );

  always #5 clk = ~clk;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [7:0] filler_byte();
    int r;
    int k;
    r = $urandom_range(0, 9);
    k = $urandom_range(0, KW_NUM - 1);
    if (r < 5) return KW_SEQ[k][$urandom_range(0, KW_LEN[k] - 1)];
    if (r < 8) return 8'($urandom_range(8'h2d, 8'h7a));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic append_filler(input int n);
    repeat (n) name_q.insert(name_q.size(), filler_byte());
  endtask

  task automatic append_keyword(input int k, input bit broken);
    int n;
    int pos;
    int i;
    n = KW_LEN[k];
    if (broken && $urandom_range(0, 1) == 1) n = n - 1;
    for (i = 0; i < n; i++) name_q.insert(name_q.size(), KW_SEQ[k][i]);
    if (broken && n == KW_LEN[k]) begin
      pos = $urandom_range(0, n - 1);
      name_q[name_q.size() - n + pos] = 8'($urandom_range(0, 255));
    end
  endtask

  task automatic build_name();
    int mode;
    mode = $urandom_range(0, 9);
    name_q.delete();
    if ($urandom_range(0, 99) < 8) append_filler($urandom_range(8, 20));
    else append_filler($urandom_range(0, 3));
    if (mode < 6) begin
      append_keyword($urandom_range(0, KW_NUM - 1), 1'b0);
      if ($urandom_range(0, 3) == 0) begin
        append_filler($urandom_range(0, 2));
        append_keyword($urandom_range(0, KW_NUM - 1), 1'b0);
      end
    end else if (mode < 8) begin
      append_keyword($urandom_range(0, KW_NUM - 1), 1'b1);
    end
    append_filler($urandom_range(0, 4));
    if (name_q.size() == 0) name_q.insert(0, filler_byte());
  endtask

  task automatic push_byte(input logic [7:0] b, input logic last, input int gap);
    in_valid  <= 1'b1;
    name_byte <= b;
    last_byte <= last;
    do @(posedge clk); while (!in_ready);
    board.take_byte(b, last);
    bytes_moved++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_name(input bit quiet);
    int i;
    for (i = 0; i < name_q.size(); i++) begin
      push_byte(name_q[i], i == name_q.size() - 1, quiet ? 0 : gap_len());
    end
  endtask

  // Hold the sender until every pending result has come back.
  task automatic drain_wait();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_verdict(is_suspect, pick);
    rx_phase++;
    if (rx_phase % 400 == 0) rx_calm = ($urandom_range(0, 3) == 0);
    if (rx_hold > 0) begin
      rx_hold--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!rx_calm) rx_hold = gap_len();
    end
  end

  initial begin
    bit drained_mid;
    drained_mid = 1'b0;
    board = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    name_q = '{8'h00};
    send_name(1'b0);
    name_q = '{8'hff};
    send_name(1'b0);
    name_q.delete();
    append_keyword(5, 1'b0);
    send_name(1'b0);
    name_q = '{8'h00};
    append_keyword(3, 1'b0);
    send_name(1'b0);
    name_q.delete();
    append_keyword(8, 1'b0);
    void'(name_q.pop_front());
    send_name(1'b0);
    name_q.delete();
    append_keyword(1, 1'b0);
    send_name(1'b1);
    drain_wait();

    while (bytes_moved < ITEMS) begin
      build_name();
      send_name($urandom_range(0, 5) == 0);
      if (!drained_mid && bytes_moved > ITEMS / 2) begin
        drain_wait();
        drained_mid = 1'b1;
      end
    end
    in_valid <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("tb_thread_name_keyword_hasher passed");
    end else begin
      $display("tb_thread_name_keyword_hasher failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_thread_name_keyword_hasher failed");
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/tnkh_pkg.sv
hw/rtl/tnkh_cell.sv
hw/rtl/tnkh_mod.sv
hw/rtl/thread_name_keyword_hasher.sv
bench/tb_thread_name_keyword_hasher.sv
